// File: rtl/rac_pkg.sv
// ----------------------------------------------------------------------------
// Recent address cache package
// Shared types and operation codes for the recent address cache.
// ----------------------------------------------------------------------------
package rac_pkg;

  localparam int unsigned AddrW = 48;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_LOOKUP = 2'd2
  } rac_func_e;

  // Contents of one slot of the chain.
  typedef struct packed {
    logic             filled;
    logic [AddrW-1:0] addr;
  } rac_slot_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } rac_ctrl_t;

endpackage

// File: rtl/rac_if.sv
// ----------------------------------------------------------------------------
// Recent address cache channels
// Request channel (operation and address) and response channel (hit).
// ----------------------------------------------------------------------------
interface rac_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic [rac_pkg::AddrW-1:0] mac_address;

  modport source (output valid, output func, output mac_address, input ready);
  modport sink   (input valid, input func, input mac_address, output ready);
endinterface

interface rac_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink   (input valid, input hit, output ready);
endinterface

// File: rtl/rac_cell.sv
// ----------------------------------------------------------------------------
// Recent address cache cell
// One slot of the address chain: loads its neighbor's contents on a shift
// and drops its filled flag on a clear.
// ----------------------------------------------------------------------------
module rac_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rac_pkg::rac_ctrl_t ctrl_i,
  input  rac_pkg::rac_slot_t slot_i,
  output rac_pkg::rac_slot_t slot_o
);

  logic                          filled_q;
  logic [rac_pkg::AddrW-1:0]     addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      filled_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      filled_q <= slot_i.filled;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift && !ctrl_i.clear) begin
      addr_q <= slot_i.addr;
    end
  end

  assign slot_o.filled = filled_q;
  assign slot_o.addr   = addr_q;

endmodule

// File: rtl/recent_address_cache.sv
// ----------------------------------------------------------------------------
// Recent address cache
// Holds the last DEPTH 48-bit addresses with first-in-first-out replacement.
// ----------------------------------------------------------------------------
// The addresses sit in a chain of DEPTH cells. An insert shifts the new
// address into the head cell and the oldest entry falls off the tail; a
// clear empties every cell. Both answer with hit = 0 on the cycle after the
// request is taken. A lookup rotates the whole chain one cell per cycle and
// compares the tail cell against the key, so its response comes only after
// a full rotation through the single comparator at the tail. The cache
// takes one request at a time, and a new request is taken as soon as the
// previous one is finished and its response slot is free or being read.
module recent_address_cache #(
  parameter int unsigned DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rac_req_if.sink          req_i,
  rac_rsp_if.source        rsp_o
);

  localparam int unsigned CntW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  state_e                    state_q;
  logic [CntW-1:0]           cnt_q;
  logic [rac_pkg::AddrW-1:0] key_q;
  logic                      hit_acc_q;
  logic                      rsp_valid_q;
  logic                      rsp_hit_q;

  rac_pkg::rac_ctrl_t        ctrl;
  rac_pkg::rac_slot_t        slot_in  [DEPTH];
  rac_pkg::rac_slot_t        slot_out [DEPTH];

  logic                      req_accept;
  logic                      rsp_free;
  logic                      tail_match;

  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && rsp_free;
  assign req_accept  = req_i.valid && req_i.ready;

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.hit   = rsp_hit_q;

  always_comb begin
    ctrl.clear = req_accept && (req_i.func == rac_pkg::FUNC_CLEAR);
    ctrl.shift = (req_accept && (req_i.func == rac_pkg::FUNC_INSERT)) ||
                 (state_q == ST_SEARCH);
  end

  // The head takes the new address on an insert and the tail's contents while
  // the chain rotates during a lookup.
  always_comb begin
    if (state_q == ST_SEARCH) begin
      slot_in[0] = slot_out[DEPTH-1];
    end else begin
      slot_in[0].filled = 1'b1;
      slot_in[0].addr   = req_i.mac_address;
    end
    for (int i = 1; i < DEPTH; i++) begin
      slot_in[i] = slot_out[i-1];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    rac_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .slot_i (slot_in[g]),
      .slot_o (slot_out[g])
    );
  end

  assign tail_match = slot_out[DEPTH-1].filled && (slot_out[DEPTH-1].addr == key_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      key_q       <= '0;
      hit_acc_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_hit_q   <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_accept) begin
            if (req_i.func == rac_pkg::FUNC_LOOKUP) begin
              key_q     <= req_i.mac_address;
              cnt_q     <= CntW'(DEPTH - 1);
              hit_acc_q <= 1'b0;
              state_q   <= ST_SEARCH;
            end else begin
              rsp_valid_q <= 1'b1;
              rsp_hit_q   <= 1'b0;
            end
          end
        end
        ST_SEARCH: begin
          hit_acc_q <= hit_acc_q || tail_match;
          if (cnt_q == '0) begin
            rsp_valid_q <= 1'b1;
            rsp_hit_q   <= hit_acc_q || tail_match;
            state_q     <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // No request is taken while the chain is rotating.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> !req_i.ready)
    else $error("request taken during a lookup");

  // Clear and insert answer on the next cycle with no hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_accept && (req_i.func != rac_pkg::FUNC_LOOKUP)) |=> (rsp_valid_q && !rsp_hit_q))
    else $error("clear or insert did not answer with a miss");

  // A lookup starts a full rotation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_accept && (req_i.func == rac_pkg::FUNC_LOOKUP)) |=>
      ((state_q == ST_SEARCH) && (cnt_q == CntW'(DEPTH - 1)) && !rsp_valid_q))
    else $error("lookup did not start a full rotation");

  // A clear leaves the head and tail cells empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> (!slot_out[0].filled && !slot_out[DEPTH-1].filled))
    else $error("cells still filled after a clear");

endmodule

// File: tb/sv/recent_address_cache_test.sv
// ----------------------------------------------------------------------------
// Recent address cache testbench
// Sends directed and random clear, insert and lookup requests and checks
// every hit response against a software copy of the slot ring, with varying
// request gaps and response back-pressure.
// ----------------------------------------------------------------------------
module recent_address_cache_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CacheDepth = 64;
  localparam logic [1:0]  FuncUnused = 2'd3;

  // Tracks the slot ring and the queue of hit values still owed by the cache.
  class hit_scoreboard;
    logic [rac_pkg::AddrW-1:0] slot_addr [CacheDepth];
    bit                        slot_filled [CacheDepth];
    int unsigned               newest;
    bit                        hit_q [$];
    int unsigned               mismatches;

    function new();
      foreach (slot_addr[i]) slot_addr[i] = '0;
      foreach (slot_filled[i]) slot_filled[i] = 1'b0;
      newest     = CacheDepth - 1;
      mismatches = 0;
    endfunction

    function void note_request(logic [1:0] func, logic [rac_pkg::AddrW-1:0] addr);
      bit found;
      found = 1'b0;
      case (func)
        rac_pkg::FUNC_CLEAR: begin
          foreach (slot_filled[i]) slot_filled[i] = 1'b0;
          newest = CacheDepth - 1;
        end
        rac_pkg::FUNC_INSERT: begin
          newest = (newest == CacheDepth - 1) ? 0 : newest + 1;
          slot_addr[newest]   = addr;
          slot_filled[newest] = 1'b1;
        end
        rac_pkg::FUNC_LOOKUP: begin
          foreach (slot_filled[i]) begin
            if (slot_filled[i] && slot_addr[i] == addr) found = 1'b1;
          end
        end
        default: ;
      endcase
      hit_q.push_back(found);
    endfunction

    function void check_response(logic hit);
      bit want;
      if (hit_q.size() == 0) begin
        $display("%0t: response with no request outstanding, expected none, got hit %0b",
                 $time, hit);
        mismatches++;
        return;
      end
      want = hit_q.pop_front();
      if (hit !== want) begin
        $display("%0t: hit mismatch, expected %0b, got %0b", $time, want, hit);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return hit_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  rac_req_if req_if ();
  rac_rsp_if rsp_if ();

  hit_scoreboard             sb = new();
  int unsigned               send_idle_pct = 0;
  int unsigned               rsp_stall_pct = 0;
  int unsigned               long_hold_req = 0;
  logic [rac_pkg::AddrW-1:0] recent_q [$];

  recent_address_cache #(
    .DEPTH(CacheDepth)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("recent_address_cache verification failed");
    $finish;
  end

  // Response back-pressure; a long hold-off requested by the stimulus is
  // counted down here so the response slot stays full and stalls the request side.
  initial begin : rsp_ready_gen
    int unsigned hold_left;
    hold_left    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req != 0) begin
        hold_left     = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left != 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.hit);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [1:0] func,
                              input logic [rac_pkg::AddrW-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid       = 1'b1;
    req_if.func        = func;
    req_if.mac_address = addr;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(func, addr);
    if (func == rac_pkg::FUNC_INSERT) begin
      recent_q.push_back(addr);
      if (recent_q.size() > 96) void'(recent_q.pop_front());
    end
    @(negedge clk);
  endtask

  task automatic wait_for_responses();
    req_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [rac_pkg::AddrW-1:0] random_address();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      default: return raw[rac_pkg::AddrW-1:0];
    endcase
  endfunction

  // Recent inserts may since have been evicted or cleared, which is the point.
  function automatic logic [rac_pkg::AddrW-1:0] known_address();
    if (recent_q.size() == 0) return random_address();
    return recent_q[$urandom_range(recent_q.size() - 1)];
  endfunction

  task automatic send_random_request();
    int unsigned               roll;
    logic [rac_pkg::AddrW-1:0] addr;
    roll = $urandom_range(299);
    if (roll < 2) begin
      send_request(rac_pkg::FUNC_CLEAR, random_address());
    end else if (roll < 20) begin
      addr = $urandom_range(1) ? known_address() : random_address();
      send_request(FuncUnused, addr);
    end else if (roll < 155) begin
      addr = ($urandom_range(4) == 0) ? known_address() : random_address();
      send_request(rac_pkg::FUNC_INSERT, addr);
    end else begin
      case ($urandom_range(9))
        0, 1, 2: addr = random_address();
        3, 4:    addr = known_address() ^ (48'd1 << $urandom_range(rac_pkg::AddrW - 1));
        default: addr = known_address();
      endcase
      send_request(rac_pkg::FUNC_LOOKUP, addr);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.func        = rac_pkg::FUNC_CLEAR;
    req_if.mac_address = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Empty cache, unused selector, extremes, near misses, duplicates, clear.
    send_request(rac_pkg::FUNC_LOOKUP, '0);
    send_request(rac_pkg::FUNC_LOOKUP, '1);
    send_request(FuncUnused, '1);
    send_request(rac_pkg::FUNC_INSERT, '0);
    send_request(rac_pkg::FUNC_INSERT, '1);
    send_request(rac_pkg::FUNC_LOOKUP, '0);
    send_request(rac_pkg::FUNC_LOOKUP, '1);
    send_request(rac_pkg::FUNC_LOOKUP, 48'h0000_0000_0001);
    send_request(rac_pkg::FUNC_LOOKUP, 48'h7FFF_FFFF_FFFF);
    send_request(rac_pkg::FUNC_INSERT, '0);
    send_request(FuncUnused, '0);
    send_request(rac_pkg::FUNC_LOOKUP, '0);
    send_request(rac_pkg::FUNC_INSERT, 48'hA5A5_A5A5_A5A5);
    send_request(rac_pkg::FUNC_CLEAR, '1);
    send_request(rac_pkg::FUNC_LOOKUP, '0);
    send_request(rac_pkg::FUNC_LOOKUP, '1);
    send_request(rac_pkg::FUNC_INSERT, 48'h5A5A_5A5A_5A5A);
    send_request(rac_pkg::FUNC_LOOKUP, 48'h5A5A_5A5A_5A5A);
    send_request(rac_pkg::FUNC_LOOKUP, 48'hA5A5_A5A5_A5A5);
    wait_for_responses();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1:       begin send_idle_pct = 48; rsp_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  rsp_stall_pct = 48; end
        default: begin send_idle_pct = 22; rsp_stall_pct = 22; end
      endcase
      for (int n = 0; n < 420; n++) begin
        if (phase == 0 && n == 200) long_hold_req = 300;
        send_random_request();
      end
      wait_for_responses();
    end

    repeat (2 * CacheDepth + 8) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("recent_address_cache verification clean");
    end else begin
      $display("recent_address_cache verification failed");
    end
    $finish;
  end

endmodule
